// ===== sv/d2q9bgk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// D2Q9 BGK collision package
// Shared field types, lattice direction tables, pipeline latencies and the
// saturation helper used by the collision core and its lanes.
// ----------------------------------------------------------------------------
package d2q9bgk_pkg;

  // Field and accumulator widths.
  localparam int unsigned FW         = 20;
  localparam int unsigned SUM_W      = 24;
  localparam int unsigned NDIR       = 9;
  localparam int unsigned OMEGA_W    = 17;
  localparam int unsigned OMEGA_FRAC = 16;
  localparam logic [OMEGA_W-1:0] OMEGA_RESET = 17'h10000;

  // Pipeline depths: quotient bits of the velocity divider, its stages,
  // the direction lane stages and the whole path from request to result.
  localparam int unsigned QBITS     = 21;
  localparam int unsigned DIV_LAT   = QBITS + 2;
  localparam int unsigned LANE_LAT  = 10;
  localparam int unsigned TOTAL_LAT = 1 + DIV_LAT + LANE_LAT + 1;

  localparam logic signed [63:0] FIX_MAX = 64'sd524287;
  localparam logic signed [63:0] FIX_MIN = -64'sd524288;

  // Lattice velocities in the order rest, E, N, W, S, NE, NW, SW, SE.
  localparam int DIR_X [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int DIR_Y [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
  // Weights k/36 written as (2^shl / 9) / 2^she: 4/9, 1/9 and 1/36.
  localparam int WT_SHL [NDIR] = '{2, 0, 0, 0, 0, 0, 0, 0, 0};
  localparam int WT_SHE [NDIR] = '{0, 0, 0, 0, 0, 2, 2, 2, 2};

  typedef logic signed [FW-1:0] fix_t;

  typedef struct packed {
    fix_t dist_rest;
    fix_t dist_east;
    fix_t dist_north;
    fix_t dist_west;
    fix_t dist_south;
    fix_t dist_northeast;
    fix_t dist_northwest;
    fix_t dist_southwest;
    fix_t dist_southeast;
  } cell_in_t;

  typedef struct packed {
    fix_t post_rest;
    fix_t post_east;
    fix_t post_north;
    fix_t post_west;
    fix_t post_south;
    fix_t post_northeast;
    fix_t post_northwest;
    fix_t post_southwest;
    fix_t post_southeast;
    fix_t density;
    fix_t velocity_x;
    fix_t velocity_y;
  } cell_out_t;

  // Clamp a signed value into the 20-bit field range.
  function automatic fix_t sat_fix(input logic signed [63:0] v);
    fix_t r;
    if (v > FIX_MAX) begin
      r = fix_t'(FIX_MAX);
    end else if (v < FIX_MIN) begin
      r = fix_t'(FIX_MIN);
    end else begin
      r = fix_t'(v);
    end
    return r;
  endfunction

endpackage

// ===== sv/d2q9_bgk_cell_collision_core.sv =====
`timescale 1ns / 1ps
// Throughput: one cell per clock; busy stays low, so a request is taken every cycle.
// The depth is set mostly by the 21 trial-subtraction stages of the velocity divider
// and the ten-stage direction lanes. Results cannot be stalled by the receiver.
// Reset clears the valid pipeline and sets the relaxation rate to 1.0.
// ----------------------------------------------------------------------------
// D2Q9 BGK cell collision core
// Sums density and momentum, divides for velocity in two divider lanes and
// relaxes all nine distributions in parallel direction lanes.
// ----------------------------------------------------------------------------
module d2q9_bgk_cell_collision_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  d2q9bgk_pkg::cell_in_t                 cell_i,
  output logic                                  done_o,
  output d2q9bgk_pkg::cell_out_t                result_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [d2q9bgk_pkg::OMEGA_W-1:0]       cfg_data_i
);

  localparam int unsigned FW    = d2q9bgk_pkg::FW;
  localparam int unsigned SW    = d2q9bgk_pkg::SUM_W;
  localparam int unsigned ND    = d2q9bgk_pkg::NDIR;
  localparam int unsigned DLAT  = d2q9bgk_pkg::DIV_LAT;
  localparam int unsigned LLAT  = d2q9bgk_pkg::LANE_LAT;
  localparam int unsigned TLAT  = d2q9bgk_pkg::TOTAL_LAT;

  logic                                accept;
  logic [TLAT-1:0]                     vld_q;
  logic [d2q9bgk_pkg::OMEGA_W-1:0]     omega_q;

  d2q9bgk_pkg::fix_t         f_in [ND];
  d2q9bgk_pkg::fix_t         f1_q [ND];
  logic signed [SW-1:0]      rho_d, mx_d, my_d, rho_q, mx_q, my_q;
  d2q9bgk_pkg::fix_t         rho_sat;
  d2q9bgk_pkg::fix_t         fd_q   [DLAT][ND];
  d2q9bgk_pkg::fix_t         rhod_q [DLAT];
  d2q9bgk_pkg::fix_t         ux, uy;
  logic signed [2*FW-1:0]    sqx_q, sqy_q;
  d2q9bgk_pkg::fix_t         post [ND];
  d2q9bgk_pkg::fix_t         densd_q [LLAT];
  d2q9bgk_pkg::fix_t         uxd_q   [LLAT];
  d2q9bgk_pkg::cell_out_t    res_q;
  d2q9bgk_pkg::fix_t         uyd_q   [LLAT];

  // The pipeline never stalls, so requests are always taken.
  assign busy        = 1'b0;
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  // Control state: valid pipeline and relaxation rate.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      omega_q <= d2q9bgk_pkg::OMEGA_RESET;
    end else begin
      vld_q <= {vld_q[TLAT-2:0], accept};
      if (cfg_valid_i && cfg_ready_o) begin
        omega_q <= cfg_data_i;
      end
    end
  end

  // Density and momentum sums of the incoming cell.
  always_comb begin
    f_in[0] = cell_i.dist_rest;
    f_in[1] = cell_i.dist_east;
    f_in[2] = cell_i.dist_north;
    f_in[3] = cell_i.dist_west;
    f_in[4] = cell_i.dist_south;
    f_in[5] = cell_i.dist_northeast;
    f_in[6] = cell_i.dist_northwest;
    f_in[7] = cell_i.dist_southwest;
    f_in[8] = cell_i.dist_southeast;
    rho_d = '0;
    for (int i = 0; i < ND; i++) begin
      rho_d = rho_d + SW'(f_in[i]);
    end
    mx_d = SW'(f_in[1]) + SW'(f_in[5]) + SW'(f_in[8])
         - SW'(f_in[3]) - SW'(f_in[6]) - SW'(f_in[7]);
    my_d = SW'(f_in[2]) + SW'(f_in[5]) + SW'(f_in[6])
         - SW'(f_in[4]) - SW'(f_in[7]) - SW'(f_in[8]);
  end

  assign rho_sat = d2q9bgk_pkg::sat_fix(rho_q);

  // Payload pipeline: sums, delay lines and shared velocity squares.
  always_ff @(posedge clk_i) begin
    f1_q  <= f_in;
    rho_q <= rho_d;
    mx_q  <= mx_d;
    my_q  <= my_d;
    fd_q[0]   <= f1_q;
    rhod_q[0] <= rho_sat;
    for (int k = 1; k < DLAT; k++) begin
      fd_q[k]   <= fd_q[k-1];
      rhod_q[k] <= rhod_q[k-1];
    end
    sqx_q <= ux * ux;
    sqy_q <= uy * uy;
    densd_q[0] <= rhod_q[DLAT-1];
    uxd_q[0]   <= ux;
    uyd_q[0]   <= uy;
    for (int k = 1; k < LLAT; k++) begin
      densd_q[k] <= densd_q[k-1];
      uxd_q[k]   <= uxd_q[k-1];
      uyd_q[k]   <= uyd_q[k-1];
    end
  end

  // Velocity lanes.
  d2q9bgk_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk_i (clk_i),
    .mom_i (mx_q),
    .rho_i (rho_q),
    .vel_o (ux)
  );

  d2q9bgk_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk_i (clk_i),
    .mom_i (my_q),
    .rho_i (rho_q),
    .vel_o (uy)
  );

  // One collision lane per lattice direction.
  for (genvar d = 0; d < ND; d++) begin : g_dir
    d2q9bgk_dir_lane #(.FRAC_BITS(FRAC_BITS), .DIR(d)) u_lane (
      .clk_i   (clk_i),
      .ux_i    (ux),
      .uy_i    (uy),
      .rho_i   (rhod_q[DLAT-1]),
      .f_i     (fd_q[DLAT-1][d]),
      .sqx_i   (sqx_q),
      .sqy_i   (sqy_q),
      .omega_i (omega_q),
      .post_o  (post[d])
    );
  end

  // Merge the lane results with density and velocity into one result.
  always_ff @(posedge clk_i) begin
    res_q.post_rest      <= post[0];
    res_q.post_east      <= post[1];
    res_q.post_north     <= post[2];
    res_q.post_west      <= post[3];
    res_q.post_south     <= post[4];
    res_q.post_northeast <= post[5];
    res_q.post_northwest <= post[6];
    res_q.post_southwest <= post[7];
    res_q.post_southeast <= post[8];
    res_q.density        <= densd_q[LLAT-1];
    res_q.velocity_x     <= uxd_q[LLAT-1];
    res_q.velocity_y     <= uyd_q[LLAT-1];
  end

  assign done_o   = vld_q[TLAT-1];
  assign result_o = res_q;

endmodule

// ===== sv/d2q9bgk_div_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Velocity divider lane
// Pipelined restoring divider, one quotient bit per stage, giving
// momentum * 2^FRAC_BITS / density rounded to nearest and saturated.
// ----------------------------------------------------------------------------
module d2q9bgk_div_lane #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic signed [d2q9bgk_pkg::SUM_W-1:0]  mom_i,
  input  logic signed [d2q9bgk_pkg::SUM_W-1:0]  rho_i,
  output d2q9bgk_pkg::fix_t                     vel_o
);

  localparam int unsigned SW    = d2q9bgk_pkg::SUM_W;
  localparam int unsigned QB    = d2q9bgk_pkg::QBITS;
  localparam int unsigned NUM_W = FRAC_BITS + 26;
  localparam int unsigned REM_W = (NUM_W > 46) ? NUM_W : 46;

  logic [SW-1:0]    mag;
  logic [SW-2:0]    rho_pos;
  logic [SW-1:0]    den;
  logic [REM_W-1:0] num;
  logic             ovf;

  logic [REM_W-1:0] rem_q  [QB+1];
  logic [QB-1:0]    quo_q  [QB+1];
  logic [SW-1:0]    den_q  [QB+1];
  logic             neg_q  [QB+1];
  logic             zero_q [QB+1];
  logic             ovf_q  [QB+1];

  logic [QB-1:0]      qmag;
  logic signed [QB:0] qsig;
  d2q9bgk_pkg::fix_t  vel_d, vel_q;

  // Numerator 2|m|*2^F + rho and denominator 2*rho realize round half away.
  always_comb begin
    mag     = mom_i[SW-1] ? SW'(-mom_i) : SW'(mom_i);
    rho_pos = rho_i[SW-2:0];
    den     = {rho_pos, 1'b0};
    num     = (REM_W'(mag) << (FRAC_BITS + 1)) + REM_W'(rho_pos);
    ovf     = num >= (REM_W'(den) << QB);
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= num;
    quo_q[0]  <= '0;
    den_q[0]  <= den;
    neg_q[0]  <= mom_i[SW-1];
    zero_q[0] <= (rho_i <= 0);
    ovf_q[0]  <= ovf;
  end

  // One trial subtraction of the shifted divisor per stage, MSB first.
  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int unsigned B = QB - 1 - k;
    logic [REM_W:0] trial;
    logic           ge;

    always_comb begin
      trial = {1'b0, rem_q[k]} - ({1'b0, REM_W'(den_q[k])} << B);
      ge    = !trial[REM_W];
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1]    <= ge ? trial[REM_W-1:0] : rem_q[k];
      quo_q[k+1]    <= quo_q[k] | (QB'(ge) << B);
      den_q[k+1]    <= den_q[k];
      neg_q[k+1]    <= neg_q[k];
      zero_q[k+1]   <= zero_q[k];
      ovf_q[k+1]    <= ovf_q[k];
    end
  end

  // Apply the sign, saturate, and force zero for a non-positive density.
  always_comb begin
    qmag  = ovf_q[QB] ? '1 : quo_q[QB];
    qsig  = neg_q[QB] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    vel_d = zero_q[QB] ? '0 : d2q9bgk_pkg::sat_fix(qsig);
  end

  always_ff @(posedge clk_i) begin
    vel_q <= vel_d;
  end

  assign vel_o = vel_q;

endmodule

// ===== sv/d2q9bgk_dir_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Direction lane
// Ten-stage pipeline for one lattice direction: equilibrium polynomial,
// weighted product with density, division by 9*2^(F+WT_SHE) and BGK relaxation.
// ----------------------------------------------------------------------------
module d2q9bgk_dir_lane #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned DIR       = 0
) (
  input  logic                                      clk_i,
  input  d2q9bgk_pkg::fix_t                         ux_i,
  input  d2q9bgk_pkg::fix_t                         uy_i,
  input  d2q9bgk_pkg::fix_t                         rho_i,
  input  d2q9bgk_pkg::fix_t                         f_i,
  input  logic signed [2*d2q9bgk_pkg::FW-1:0]       sqx_i,
  input  logic signed [2*d2q9bgk_pkg::FW-1:0]       sqy_i,
  input  logic [d2q9bgk_pkg::OMEGA_W-1:0]           omega_i,
  output d2q9bgk_pkg::fix_t                         post_o
);

  localparam int unsigned FW   = d2q9bgk_pkg::FW;
  localparam int          CX   = d2q9bgk_pkg::DIR_X[DIR];
  localparam int          CY   = d2q9bgk_pkg::DIR_Y[DIR];
  localparam int unsigned ASH  = d2q9bgk_pkg::WT_SHL[DIR];
  localparam int unsigned EXPO = FRAC_BITS + d2q9bgk_pkg::WT_SHE[DIR];
  localparam int unsigned TA   = 2 * FRAC_BITS + 4;
  localparam int unsigned TB   = FRAC_BITS + 26;
  localparam int unsigned TAB  = (TA > TB) ? TA : TB;
  localparam int unsigned TW   = (TAB > 48) ? TAB : 48;
  localparam int unsigned PCW  = FRAC_BITS + 28;
  localparam int unsigned CW   = ((TW > PCW) ? TW : PCW) + 1;
  localparam int unsigned LO_W = PCW / 2;
  localparam int unsigned HI_W = PCW - LO_W;
  localparam int unsigned PP_W = FW + PCW + 1;
  localparam int unsigned NM_W = PP_W + 2;
  localparam int unsigned T_W  = NM_W + 1;
  localparam int unsigned TC_W = 24;
  localparam int unsigned RSH  = 28;
  localparam int unsigned QM_W = TC_W + 25;
  localparam int unsigned OM_W = FW + 1 + d2q9bgk_pkg::OMEGA_W + 1;
  localparam logic [24:0] RECIP9 = 25'd29826162;
  localparam logic [TC_W-1:0] T_MAX = 24'd9437184;
  localparam logic signed [TW-1:0] TWICE_ONE = TW'(1) << (2 * FRAC_BITS + 1);
  localparam logic signed [TW-1:0] HALF_P    = TW'(1) << FRAC_BITS;
  localparam logic signed [CW-1:0] P_LIM     = CW'(1) << (FRAC_BITS + 26);
  localparam logic signed [OM_W-1:0] OM_HALF =
    OM_W'(1) << (d2q9bgk_pkg::OMEGA_FRAC - 1);

  // Stage registers.
  d2q9bgk_pkg::fix_t f_q [1:9];
  d2q9bgk_pkg::fix_t rho_q [1:3];
  logic signed [FW:0]         cu_q;
  logic signed [2*FW+1:0]     cu2_q;
  logic signed [TW-1:0]       tw_q;
  logic signed [PCW-1:0]      poly_q;
  logic signed [FW+LO_W:0]    pplo_q;
  logic signed [FW+HI_W-1:0]  pphi_q;
  logic signed [PP_W-1:0]     prod_q;
  logic [TC_W-1:0]            tc_q;
  logic                       neg6_q, neg7_q;
  logic [QM_W-1:0]            qm_q;
  logic signed [FW:0]         diff_q;
  logic signed [OM_W-1:0]     om_q;
  d2q9bgk_pkg::fix_t          post_q;

  logic signed [FW:0]     cx_t, cy_t, cu_d;
  logic signed [TW-1:0]   t_cu, t_c2, t_sq, tw_d;
  logic signed [CW-1:0]   pf, pc;
  logic signed [NM_W-1:0] num;
  logic [NM_W-1:0]        nmag;
  logic [T_W-1:0]         biased, tq;
  logic [TC_W-1:0]        tc_d;
  logic [FW:0]            qv;
  logic signed [FW+1:0]   qs;
  d2q9bgk_pkg::fix_t      feq;
  logic signed [OM_W-1:0] adj;

  // Stage 1: projection of the velocity on this direction and its square.
  always_comb begin
    cx_t = (CX == 1) ? (FW+1)'(ux_i) : (CX == -1) ? -(FW+1)'(ux_i) : '0;
    cy_t = (CY == 1) ? (FW+1)'(uy_i) : (CY == -1) ? -(FW+1)'(uy_i) : '0;
    cu_d = cx_t + cy_t;
  end

  // Stage 2: twice the polynomial scaled by 2^(2F).
  always_comb begin
    t_cu = TW'(cu_q) <<< FRAC_BITS;
    t_c2 = TW'(cu2_q);
    t_sq = TW'(sqx_i) + TW'(sqy_i);
    tw_d = TWICE_ONE + (t_cu <<< 2) + (t_cu <<< 1) + (t_c2 <<< 3) + t_c2
           - (t_sq <<< 1) - t_sq;
  end

  // Stage 3: round to F fraction bits and clamp far beyond saturation.
  always_comb begin
    pf = CW'((tw_q + HALF_P) >>> (FRAC_BITS + 1));
    if (pf > P_LIM) begin
      pc = P_LIM;
    end else if (pf < -P_LIM) begin
      pc = -P_LIM;
    end else begin
      pc = pf;
    end
  end

  // Stage 6: magnitude, rounding bias and shift ahead of the divide by 9.
  always_comb begin
    num    = NM_W'(prod_q) <<< ASH;
    nmag   = num[NM_W-1] ? NM_W'(-num) : NM_W'(num);
    biased = T_W'(nmag) + (T_W'(9) << (EXPO - 1));
    tq     = biased >> EXPO;
    tc_d   = (tq >= T_W'(T_MAX)) ? T_MAX : tq[TC_W-1:0];
  end

  // Stage 8: quotient by 9, sign and saturation of the equilibrium.
  always_comb begin
    qv  = qm_q[RSH +: FW+1];
    qs  = neg7_q ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
    feq = d2q9bgk_pkg::sat_fix(qs);
  end

  // Stage 10: relaxation step rounded half up.
  always_comb begin
    adj = (om_q + OM_HALF) >>> d2q9bgk_pkg::OMEGA_FRAC;
  end

  always_ff @(posedge clk_i) begin
    f_q[1]   <= f_i;
    rho_q[1] <= rho_i;
    for (int k = 2; k <= 9; k++) begin
      f_q[k] <= f_q[k-1];
    end
    for (int k = 2; k <= 3; k++) begin
      rho_q[k] <= rho_q[k-1];
    end
    cu_q   <= cu_d;
    cu2_q  <= cu_d * cu_d;
    tw_q   <= tw_d;
    poly_q <= PCW'(pc);
    pplo_q <= rho_q[3] * $signed({1'b0, poly_q[LO_W-1:0]});
    pphi_q <= rho_q[3] * $signed(poly_q[PCW-1:LO_W]);
    prod_q <= (PP_W'(pphi_q) <<< LO_W) + PP_W'(pplo_q);
    tc_q   <= tc_d;
    neg6_q <= prod_q[PP_W-1];
    qm_q   <= QM_W'(tc_q) * QM_W'(RECIP9);
    neg7_q <= neg6_q;
    diff_q <= (FW+1)'(feq) - (FW+1)'(f_q[7]);
    om_q   <= OM_W'(diff_q) * $signed({1'b0, omega_i});
    post_q <= d2q9bgk_pkg::sat_fix(adj + OM_W'(f_q[9]));
  end

  assign post_o = post_q;

endmodule

// ===== sv/d2q9bgk_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// D2Q9 BGK collision port checker
// Watches the core's ports for fixed latency, a never-stalled request side
// and zero velocity on cells without positive density.
// ----------------------------------------------------------------------------
module d2q9bgk_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start,
  input logic                    busy,
  input logic                    done_o,
  input d2q9bgk_pkg::cell_out_t  result_o
);

  // Every accepted request yields its result after the fixed latency.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##(d2q9bgk_pkg::TOTAL_LAT) done_o)
    else $error("result strobe missing after fixed latency");

  // The request side is never held off.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  // A cell without positive density reports zero velocity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (result_o.density <= 0) |->
      (result_o.velocity_x == 0) && (result_o.velocity_y == 0))
    else $error("nonzero velocity for non-positive density");

endmodule

bind d2q9_bgk_cell_collision_core d2q9bgk_checker u_d2q9bgk_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);

// ===== verif/d2q9_bgk_cell_collision_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// D2Q9 BGK cell collision core testbench
// Drives cells through the core under several relaxation rates and idle
// patterns, predicts every result in 64-bit integer arithmetic and checks
// each done strobe against the oldest pending prediction.
// ----------------------------------------------------------------------------
module d2q9_bgk_cell_collision_core_test;

  localparam int unsigned LATENCY   = 35;
  localparam int unsigned WDOG_MAX  = 2000;
  localparam int unsigned NRANDOM   = 400;

  // Collision predictor with its own copy of the relaxation rate.
  class collision_scoreboard;
    logic [d2q9bgk_pkg::OMEGA_W-1:0] omega;
    d2q9bgk_pkg::cell_out_t          pending[$];
    int                              errors;

    function new();
      omega  = d2q9bgk_pkg::OMEGA_RESET;
      errors = 0;
    endfunction

    function longint clamp(longint v);
      if (v > 524287) begin
        return 524287;
      end
      if (v < -524288) begin
        return -524288;
      end
      return v;
    endfunction

    // Floor of v / 2^s without shifting a negative value.
    function longint floor_pow2(longint v, int s);
      if (v >= 0) begin
        return v >>> s;
      end
      return -((-(v + 1)) >>> s) - 1;
    endfunction

    function longint round_up_pow2(longint v, int s);
      return floor_pow2(v + (longint'(1) << (s - 1)), s);
    endfunction

    // Nearest quotient, ties away from zero; den is positive.
    function longint div_nearest(longint num, longint den);
      if (num >= 0) begin
        return (num + den / 2) / den;
      end
      return -((-num + den / 2) / den);
    endfunction

    function void note_request(d2q9bgk_pkg::cell_in_t c);
      longint                 f [d2q9bgk_pkg::NDIR];
      longint                 rho, mx, my, rho_s, ux, uy, usq, cu, twice, poly, feq, post;
      longint                 wk [d2q9bgk_pkg::NDIR];
      d2q9bgk_pkg::fix_t      post_v [d2q9bgk_pkg::NDIR];
      d2q9bgk_pkg::cell_out_t r;
      wk = '{16, 4, 4, 4, 4, 1, 1, 1, 1};
      f[0] = c.dist_rest;      f[1] = c.dist_east;      f[2] = c.dist_north;
      f[3] = c.dist_west;      f[4] = c.dist_south;     f[5] = c.dist_northeast;
      f[6] = c.dist_northwest; f[7] = c.dist_southwest; f[8] = c.dist_southeast;
      rho = 0; mx = 0; my = 0; ux = 0; uy = 0;
      for (int i = 0; i < d2q9bgk_pkg::NDIR; i++) begin
        rho += f[i];
        mx  += f[i] * d2q9bgk_pkg::DIR_X[i];
        my  += f[i] * d2q9bgk_pkg::DIR_Y[i];
      end
      if (rho > 0) begin
        ux = clamp(div_nearest(mx * 65536, rho));
        uy = clamp(div_nearest(my * 65536, rho));
      end
      rho_s = clamp(rho);
      usq = ux * ux + uy * uy;
      for (int i = 0; i < d2q9bgk_pkg::NDIR; i++) begin
        cu    = d2q9bgk_pkg::DIR_X[i] * ux + d2q9bgk_pkg::DIR_Y[i] * uy;
        twice = (longint'(1) << 33) + 6 * cu * 65536 + 9 * cu * cu - 3 * usq;
        poly  = round_up_pow2(twice, 17);
        feq   = clamp(div_nearest(wk[i] * rho_s * poly, 36 * 65536));
        post  = f[i] + round_up_pow2(longint'(omega) * (feq - f[i]),
                                     d2q9bgk_pkg::OMEGA_FRAC);
        post_v[i] = d2q9bgk_pkg::fix_t'(clamp(post));
      end
      r.post_rest      = post_v[0]; r.post_east      = post_v[1];
      r.post_north     = post_v[2]; r.post_west      = post_v[3];
      r.post_south     = post_v[4]; r.post_northeast = post_v[5];
      r.post_northwest = post_v[6]; r.post_southwest = post_v[7];
      r.post_southeast = post_v[8];
      r.density    = d2q9bgk_pkg::fix_t'(rho_s);
      r.velocity_x = d2q9bgk_pkg::fix_t'(ux);
      r.velocity_y = d2q9bgk_pkg::fix_t'(uy);
      pending.push_back(r);
    endfunction

    function void check_result(d2q9bgk_pkg::cell_out_t got);
      d2q9bgk_pkg::cell_out_t exp_r;
      d2q9bgk_pkg::fix_t      e [12];
      d2q9bgk_pkg::fix_t      g [12];
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      e = {>>{exp_r}};
      g = {>>{got}};
      for (int i = 0; i < 12; i++) begin
        if (e[i] !== g[i]) begin
          $display("%0t: field %0d expected %0d actual %0d", $realtime, i, e[i], g[i]);
          errors++;
        end
      end
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  d2q9bgk_pkg::cell_in_t           cell_i = '0;
  logic                            done_o;
  d2q9bgk_pkg::cell_out_t          result_o;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [d2q9bgk_pkg::OMEGA_W-1:0] cfg_data_i = '0;

  collision_scoreboard board = new();
  int unsigned         idle_pct;
  int unsigned         quiet_cycles;

  always #10 clk_i = ~clk_i;

  d2q9_bgk_cell_collision_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cell_i      (cell_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Check results and watch for a stalled run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        board.check_result(result_o);
      end
      if (done_o || (start && !busy) || (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WDOG_MAX) begin
        $display("d2q9_bgk_cell_collision_core verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  // Send one cell request, with random idle cycles ahead of it.
  task automatic send_cell(d2q9bgk_pkg::cell_in_t c);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start  <= 1'b1;
    cell_i <= c;
    @(posedge clk_i);
    while (busy) begin
      @(posedge clk_i);
    end
    board.note_request(c);
    @(negedge clk_i);
  endtask

  // Wait out the pipeline, then write the relaxation rate.
  task automatic write_rate(logic [d2q9bgk_pkg::OMEGA_W-1:0] w);
    start <= 1'b0;
    while (board.pending.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (LATENCY + 2) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= w;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    board.omega = w;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic d2q9bgk_pkg::fix_t rand_fix();
    case ($urandom_range(3))
      0: return d2q9bgk_pkg::fix_t'($urandom);
      1: return d2q9bgk_pkg::fix_t'($urandom_range(16384) - 8192);
      default: return d2q9bgk_pkg::fix_t'($urandom_range(65536) + 4096);
    endcase
  endfunction

  function automatic d2q9bgk_pkg::cell_in_t rand_cell();
    d2q9bgk_pkg::fix_t     d [d2q9bgk_pkg::NDIR];
    d2q9bgk_pkg::cell_in_t r;
    foreach (d[i]) d[i] = rand_fix();
    r = {>>{d}};
    return r;
  endfunction

  function automatic d2q9bgk_pkg::cell_in_t fill_cell(d2q9bgk_pkg::fix_t v);
    d2q9bgk_pkg::fix_t     d [d2q9bgk_pkg::NDIR];
    d2q9bgk_pkg::cell_in_t r;
    foreach (d[i]) d[i] = v;
    r = {>>{d}};
    return r;
  endfunction

  initial begin
    d2q9bgk_pkg::cell_in_t           c;
    logic [d2q9bgk_pkg::OMEGA_W-1:0] rates [5];
    int unsigned                     pcts [4];
    rates = '{17'h10000, 17'h00000, 17'h1FFFF, 17'h0C000, 17'h00001};
    pcts  = '{0, 76, 16, 40};
    idle_pct = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed cells: extremes, zero and negative density, pure flows.
    send_cell(fill_cell(d2q9bgk_pkg::fix_t'(0)));
    send_cell(fill_cell(d2q9bgk_pkg::fix_t'(524287)));
    send_cell(fill_cell(d2q9bgk_pkg::fix_t'(-524288)));
    send_cell(fill_cell(d2q9bgk_pkg::fix_t'(-1)));
    send_cell(fill_cell(d2q9bgk_pkg::fix_t'(7282)));
    c = fill_cell(d2q9bgk_pkg::fix_t'(0)); c.dist_east = 20'sd65536;
    send_cell(c);
    c = fill_cell(d2q9bgk_pkg::fix_t'(0)); c.dist_north = 20'sd1; c.dist_rest = 20'sd1;
    send_cell(c);
    c = fill_cell(d2q9bgk_pkg::fix_t'(0)); c.dist_southwest = 20'sd524287;
    c.dist_east = 20'sd1;
    send_cell(c);
    c = fill_cell(d2q9bgk_pkg::fix_t'(0)); c.dist_west = d2q9bgk_pkg::fix_t'(-524288);
    c.dist_rest = 20'sd524287;
    send_cell(c);
    c = fill_cell(d2q9bgk_pkg::fix_t'(-524288)); c.dist_rest = 20'sd524287;
    send_cell(c);
    c = fill_cell(d2q9bgk_pkg::fix_t'(0)); c.dist_northwest = 20'sd3;
    c.dist_southeast = 20'sd2;
    send_cell(c);
    c = fill_cell(d2q9bgk_pkg::fix_t'(0)); c.dist_rest = 20'sd1;
    send_cell(c);

    // Random phases, each under its own relaxation rate and one of four idle patterns.
    for (int p = 0; p < 5; p++) begin
      write_rate(rates[p]);
      idle_pct = pcts[p % 4];
      for (int n = 0; n < NRANDOM / 5; n++) begin
        send_cell(rand_cell());
      end
    end
    write_rate(17'($urandom));
    idle_pct = 0;
    repeat (20) send_cell(rand_cell());
    start <= 1'b0;

    while (board.pending.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (LATENCY + 5) @(negedge clk_i);
    if (board.errors == 0) begin
      $display("d2q9_bgk_cell_collision_core verification clean");
    end else begin
      $display("d2q9_bgk_cell_collision_core verification failed");
    end
    $finish;
  end

endmodule
